>>> sv/bct_pkg.sv
package bct_pkg;

  localparam int REQ_W   = 2;
  localparam int ET_W    = 16;
  localparam int COORD_W = 12;
  localparam int POS_W   = 21;
  localparam int RAD_W   = 18;
  localparam int LIFE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // The queue pointers wrap by plain increment, so the depth is a power of two.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic              tick;
    logic              kill;
    logic              query;
    logic [ET_W-1:0]    et;
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RAD_W-1:0]        radius;
    logic [LIFE_W-1:0]       life_status;
    logic                    hit;
  } result_t;

endpackage

>>> sv/bct_front.sv
module bct_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,
  input  logic [bct_pkg::REQ_W-1:0]     s_tuser,
  output logic                          q_valid,
  output bct_pkg::item_t                q_item,
  input  logic                          q_pop
);
  import bct_pkg::*;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_KILL  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  item_t            item_in;
  logic             push;

  always_comb begin
    item_in.tick  = 1'b0;
    item_in.kill  = 1'b0;
    item_in.query = 1'b0;
    item_in.et    = s_tdata[15:0];
    item_in.mx    = s_tdata[27:16];
    item_in.my    = s_tdata[39:28];
    unique case (s_tuser)
      REQ_TICK:  item_in.tick  = 1'b1;
      REQ_KILL:  item_in.kill  = 1'b1;
      REQ_QUERY: item_in.query = 1'b1;
      REQ_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign s_tready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

endmodule

>>> sv/bct_back.sv
module bct_back #(
  parameter int DYING_FRAMES = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  bct_pkg::cfg_wr_t cfg,
  input  logic             q_valid,
  input  bct_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output bct_pkg::result_t res
);
  import bct_pkg::*;

  localparam logic [LIFE_W-1:0] LIFE_ALIVE = 2'd0;
  localparam logic [LIFE_W-1:0] LIFE_DYING = 2'd1;
  localparam logic [LIFE_W-1:0] LIFE_DEAD  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_W        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_H        = 3'd6;

  localparam logic [RAD_W-1:0]   RST_RADIUS = 18'd2560;
  localparam logic [COORD_W-1:0] RST_WIN_W  = 12'd640;
  localparam logic [COORD_W-1:0] RST_WIN_H  = 12'd480;

  localparam logic [7:0] FRAMES_INIT = 8'(DYING_FRAMES);
  localparam logic signed [23:0] DRIFT = 24'((256 + DYING_FRAMES / 2) / DYING_FRAMES);

  // Exact floor division of the 26-bit radius product by the frame count.
  localparam int RSHIFT = 26 + $clog2(DYING_FRAMES);
  localparam logic [27:0] RECIP = 28'(((64'd1 << RSHIFT) + 64'(DYING_FRAMES) - 64'd1)
                                      / 64'(DYING_FRAMES));

  localparam logic signed [23:0] POS_MAX = 24'sd1048575;
  localparam logic signed [23:0] POS_MIN = -24'sd1048576;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
  } axis_t;

  function automatic logic signed [23:0] sx21(input logic signed [POS_W-1:0] a);
    sx21 = {{3{a[POS_W-1]}}, a};
  endfunction

  function automatic logic signed [POS_W-1:0] sat21(input logic signed [23:0] v);
    if (v > POS_MAX) begin
      sat21 = POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      sat21 = POS_MIN[POS_W-1:0];
    end else begin
      sat21 = v[POS_W-1:0];
    end
  endfunction

  function automatic axis_t move_axis(
    input logic signed [POS_W-1:0] pos,
    input logic signed [POS_W-1:0] step,
    input logic signed [POS_W-1:0] vel,
    input logic [RAD_W-1:0]        r,
    input logic [COORD_W-1:0]      win
  );
    logic signed [23:0] p;
    logic signed [23:0] r24;
    logic signed [23:0] lim;
    logic signed [POS_W-1:0] v;
    r24 = $signed({6'b0, r});
    lim = $signed({4'b0, win, 8'b0});
    p = sx21(sat21(sx21(pos) + sx21(step)));
    v = vel;
    if (p < 0) begin
      p = sx21(sat21(-p));
      v = sat21(-sx21(v));
    end
    if (p + (r24 <<< 1) > lim) begin
      p = sx21(sat21((lim <<< 1) - (r24 <<< 2) - p));
      v = sat21(-sx21(v));
    end
    move_axis.pos = p[POS_W-1:0];
    move_axis.vel = v;
  endfunction

  logic signed [POS_W-1:0] pos_x, pos_x_next;
  logic signed [POS_W-1:0] pos_y, pos_y_next;
  logic signed [POS_W-1:0] vel_x, vel_x_next;
  logic signed [POS_W-1:0] vel_y, vel_y_next;
  logic [RAD_W-1:0]        rad, rad_next;
  logic [LIFE_W-1:0]       life, life_next;
  logic [7:0]              frames, frames_next;
  logic [RAD_W-1:0]        start_radius, start_radius_next;
  logic [COORD_W-1:0]      win_w, win_w_next;
  logic [COORD_W-1:0]      win_h, win_h_next;
  logic                    phase, phase_next;

  logic signed [36:0] prod_x;
  logic signed [36:0] prod_y;
  logic [25:0]        prod_r;
  logic [53:0]        qprod;
  logic               load_prod;
  logic               emit;
  logic               en;
  axis_t              ax;
  axis_t              ay;

  logic signed [22:0] dx;
  logic signed [22:0] dy;

  logic                    v1;
  logic signed [POS_W-1:0] s1_pos_x;
  logic signed [POS_W-1:0] s1_pos_y;
  logic [RAD_W-1:0]        s1_rad;
  logic [LIFE_W-1:0]       s1_life;
  logic                    s1_query;
  logic signed [22:0]      s1_dx;
  logic signed [22:0]      s1_dy;

  logic                    v2;
  logic signed [POS_W-1:0] s2_pos_x;
  logic signed [POS_W-1:0] s2_pos_y;
  logic [RAD_W-1:0]        s2_rad;
  logic [LIFE_W-1:0]       s2_life;
  logic                    s2_query;
  logic signed [45:0]      s2_sq_x;
  logic signed [45:0]      s2_sq_y;
  logic [35:0]             s2_rr;
  logic [44:0]             dsq_sum;

  assign en = !res_valid || res_ready;

  assign ax    = move_axis(pos_x, prod_x[36:16], vel_x, rad, win_w);
  assign ay    = move_axis(pos_y, prod_y[36:16], vel_y, rad, win_h);
  assign qprod = prod_r * RECIP;

  assign dx = {{2{pos_x[POS_W-1]}}, pos_x} + $signed({5'b0, rad})
              - $signed({3'b0, q_item.mx, 8'b0});
  assign dy = {{2{pos_y[POS_W-1]}}, pos_y} + $signed({5'b0, rad})
              - $signed({3'b0, q_item.my, 8'b0});

  always_comb begin
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;
    vel_x_next        = vel_x;
    vel_y_next        = vel_y;
    rad_next          = rad;
    life_next         = life;
    frames_next       = frames;
    start_radius_next = start_radius;
    win_w_next        = win_w;
    win_h_next        = win_h;
    phase_next        = phase;
    load_prod         = 1'b0;
    emit              = 1'b0;
    q_pop             = 1'b0;

    if (q_valid && en) begin
      if (q_item.tick) begin
        priority if (life == LIFE_ALIVE || (life == LIFE_DYING && frames != '0)) begin
          if (!phase) begin
            phase_next = 1'b1;
            load_prod  = 1'b1;
          end else begin
            phase_next = 1'b0;
            q_pop      = 1'b1;
            emit       = 1'b1;
            if (life == LIFE_ALIVE) begin
              pos_x_next = ax.pos;
              vel_x_next = ax.vel;
              pos_y_next = ay.pos;
              vel_y_next = ay.vel;
            end else begin
              rad_next    = qprod[RSHIFT +: RAD_W];
              pos_x_next  = sat21(sx21(pos_x) + DRIFT);
              pos_y_next  = sat21(sx21(pos_y) + DRIFT);
              frames_next = frames - 1'b1;
              if (frames == 8'd1) begin
                life_next = LIFE_DEAD;
              end
            end
          end
        end else if (life == LIFE_DYING) begin
          life_next = LIFE_DEAD;
          q_pop     = 1'b1;
          emit      = 1'b1;
        end else begin
          q_pop = 1'b1;
          emit  = 1'b1;
        end
      end else if (q_item.kill) begin
        vel_x_next  = '0;
        vel_y_next  = '0;
        life_next   = LIFE_DYING;
        frames_next = FRAMES_INIT;
        q_pop       = 1'b1;
        emit        = 1'b1;
      end else begin
        q_pop = 1'b1;
        emit  = 1'b1;
      end
    end

    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_START_RADIUS: begin
          start_radius_next = cfg.data[RAD_W-1:0];
          rad_next          = cfg.data[RAD_W-1:0];
        end
        CFG_START_X: pos_x_next = $signed({1'b0, cfg.data[19:0]});
        CFG_START_Y: pos_y_next = $signed({1'b0, cfg.data[19:0]});
        CFG_SPEED_X: vel_x_next = $signed(cfg.data);
        CFG_SPEED_Y: vel_y_next = $signed(cfg.data);
        CFG_WIN_W:   win_w_next = cfg.data[COORD_W-1:0];
        CFG_WIN_H:   win_h_next = cfg.data[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= '0;
      vel_x        <= '0;
      vel_y        <= '0;
      rad          <= RST_RADIUS;
      life         <= LIFE_ALIVE;
      frames       <= '0;
      start_radius <= RST_RADIUS;
      win_w        <= RST_WIN_W;
      win_h        <= RST_WIN_H;
      phase        <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      vel_x        <= vel_x_next;
      vel_y        <= vel_y_next;
      rad          <= rad_next;
      life         <= life_next;
      frames       <= frames_next;
      start_radius <= start_radius_next;
      win_w        <= win_w_next;
      win_h        <= win_h_next;
      phase        <= phase_next;
      if (en) begin
        v1        <= emit;
        v2        <= v1;
        res_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod_x <= vel_x * $signed({1'b0, q_item.et});
      prod_y <= vel_y * $signed({1'b0, q_item.et});
      prod_r <= start_radius * frames;
    end
  end

  assign dsq_sum = {1'b0, s2_sq_x[43:0]} + {1'b0, s2_sq_y[43:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos_x <= pos_x_next;
      s1_pos_y <= pos_y_next;
      s1_rad   <= rad_next;
      s1_life  <= life_next;
      s1_query <= q_item.query;
      s1_dx    <= dx;
      s1_dy    <= dy;

      s2_pos_x <= s1_pos_x;
      s2_pos_y <= s1_pos_y;
      s2_rad   <= s1_rad;
      s2_life  <= s1_life;
      s2_query <= s1_query;
      s2_sq_x  <= s1_dx * s1_dx;
      s2_sq_y  <= s1_dy * s1_dy;
      s2_rr    <= s1_rad * s1_rad;

      res.pos_x       <= s2_pos_x;
      res.pos_y       <= s2_pos_y;
      res.radius      <= s2_rad;
      res.life_status <= s2_life;
      res.hit         <= s2_query && (dsq_sum < {9'b0, s2_rr});
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    phase |-> (q_valid && q_item.tick))
    else $error("Second tick cycle without a tick at the queue head.");

  assert property (@(posedge clk) disable iff (rst)
    (life == LIFE_DYING) |-> (frames != '0))
    else $error("Dying circle with no frames left.");

  assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.kill && !cfg.valid) |=>
      (life == LIFE_DYING && frames == FRAMES_INIT && vel_x == '0 && vel_y == '0))
    else $error("Kill did not stop the circle and start the dying sequence.");

  assert property (@(posedge clk) disable iff (rst)
    (life == LIFE_DEAD && !(q_pop && q_item.kill)) |=> (life == LIFE_DEAD))
    else $error("Dead circle left the dead state without a kill.");

endmodule

>>> sv/bouncing_circle_target.sv
// Bouncing circle target. Input beats are taken one per clock into a four-entry
// queue while it has room, independently of the result side. The execution side
// retires a kill, a hit query, a tick on a dead circle or an unused request code
// in a single step, and a tick that moves or shrinks the circle in two steps: the
// first step registers the velocity-times-time or radius-times-frames product,
// the second updates position, velocity and radius, since the next item depends
// on that state. Each result passes the s1 and s2 registers, which hold the
// squared-distance hit test, and waits in an output register until it is
// taken. Configuration writes are accepted every cycle and take effect at once;
// writing a start register also loads the matching circle state.
module bouncing_circle_target #(
  parameter int DYING_FRAMES = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // elapsed_time[15:0], mouse_x[27:16], mouse_y[39:28]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // pos_x[20:0], pos_y[41:21], radius[59:42],
                                 // life_status[61:60], hit[62], zero[63]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  import bct_pkg::*;

  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  cfg_wr_t cfg;
  result_t res;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  bct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bct_back #(
    .DYING_FRAMES (DYING_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {1'b0, res.hit, res.life_status, res.radius, res.pos_y, res.pos_x};

endmodule
